/* rtl/hcbd_pkg.sv */
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, constants and a hex-digit helper for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int TOTAL_BITS     = 32;
  localparam int NIBBLE_SHIFT   = 4;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_EXT     = 3'd1,
    PH_DATA    = 3'd2,
    PH_DTRAIL  = 3'd3,
    PH_TRAILER = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } item_t;

  typedef struct packed {
    logic [7:0]            payload_byte;
    logic                  has_payload;
    logic                  body_done;
    logic [TOTAL_BITS-1:0] decoded_total;
  } result_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

/* rtl/http_chunked_body_decoder.sv */
// Each result is registered in the result queue and reaches the output from there.
// Throughput: one byte per cycle; stall rises only when the two-entry result
// queue is full, i.e. after the output side has stalled for two results.
// Reset (rst, synchronous, active high): parser returns to the size line
// with count and total at zero, and the result queue empties.
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Strips chunked transfer framing from a body byte stream, one byte a cycle while not stalled.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
  parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  hcbd_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output hcbd_pkg::result_t result
);

  hcbd_pkg::phase_t                phase;
  hcbd_pkg::phase_t                phase_next;
  logic [COUNT_BITS-1:0]           count;
  logic [COUNT_BITS-1:0]           count_next;
  logic [hcbd_pkg::TOTAL_BITS-1:0] total;
  logic [hcbd_pkg::TOTAL_BITS-1:0] total_next;
  logic                            res_valid;
  hcbd_pkg::result_t               res;
  logic                            accept;
  logic                            full;
  logic [1:0]                      fill;

  assign item_stall = full;
  assign accept     = item_valid && !full;

  hcbd_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .item      (item),
    .phase     (phase),
    .count     (count),
    .total     (total),
    .phase_next(phase_next),
    .count_next(count_next),
    .total_next(total_next),
    .res_valid (res_valid),
    .res       (res)
  );

  hcbd_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (accept && res_valid),
    .push_data   (res),
    .full        (full),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .fill        (fill)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= hcbd_pkg::PH_SIZE;
      count <= '0;
      total <= '0;
    end else if (accept) begin
      phase <= phase_next;
      count <= count_next;
      total <= total_next;
    end
  end

`ifndef SYNTH
  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && !item.restart && phase == hcbd_pkg::PH_DONE) |-> !res_valid)
    else $error("result produced after body completion");

  a_payload_xor_done: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.has_payload && result.body_done))
    else $error("result flags both payload and completion");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("result queue overfilled");

  a_total_step: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid && res.has_payload) |=> total == $past(res.decoded_total))
    else $error("decoded total not tracking payload results");
`endif

endmodule

/* rtl/hcbd_step.sv */
// ----------------------------------------------------------------------------
// hcbd_step
// Per-byte next-state and result logic of the chunked framing parser.
// ----------------------------------------------------------------------------
module hcbd_step #(
  parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEF
) (
  input  hcbd_pkg::item_t                  item,
  input  hcbd_pkg::phase_t                 phase,
  input  logic [COUNT_BITS-1:0]            count,
  input  logic [hcbd_pkg::TOTAL_BITS-1:0]  total,
  output hcbd_pkg::phase_t                 phase_next,
  output logic [COUNT_BITS-1:0]            count_next,
  output logic [hcbd_pkg::TOTAL_BITS-1:0]  total_next,
  output logic                             res_valid,
  output hcbd_pkg::result_t                res
);

  hcbd_pkg::phase_t               ph;
  logic [COUNT_BITS-1:0]          cnt;
  logic [COUNT_BITS-1:0]          cnt_dec;
  logic [hcbd_pkg::TOTAL_BITS-1:0] tot;
  logic [hcbd_pkg::TOTAL_BITS-1:0] tot_inc;
  logic [4:0]                     hex;
  logic                           is_lf;
  logic                           is_cr;

  always_comb begin
    ph         = item.restart ? hcbd_pkg::PH_SIZE : phase;
    cnt        = item.restart ? '0 : count;
    tot        = item.restart ? '0 : total;
    cnt_dec    = cnt - COUNT_BITS'(1);
    tot_inc    = tot + hcbd_pkg::TOTAL_BITS'(1);
    hex        = hcbd_pkg::hex_decode(item.in_byte);
    is_lf      = (item.in_byte == hcbd_pkg::CH_LF);
    is_cr      = (item.in_byte == hcbd_pkg::CH_CR);
    phase_next = ph;
    count_next = cnt;
    total_next = tot;
    res_valid  = 1'b0;
    res        = '0;
    unique case (ph)
      hcbd_pkg::PH_SIZE, hcbd_pkg::PH_EXT: begin
        if (is_lf) begin
          if (cnt == '0) begin
            phase_next = hcbd_pkg::PH_TRAILER;
            count_next = COUNT_BITS'(1);
          end else begin
            phase_next = hcbd_pkg::PH_DATA;
          end
        end else if (ph == hcbd_pkg::PH_SIZE) begin
          if (hex[4]) begin
            count_next = (cnt << hcbd_pkg::NIBBLE_SHIFT) | COUNT_BITS'(hex[3:0]);
          end else if (!is_cr) begin
            phase_next = hcbd_pkg::PH_EXT;
          end
        end
      end
      hcbd_pkg::PH_DATA: begin
        count_next        = cnt_dec;
        total_next        = tot_inc;
        if (cnt_dec == '0) begin
          phase_next = hcbd_pkg::PH_DTRAIL;
        end
        res_valid         = 1'b1;
        res.payload_byte  = item.in_byte;
        res.has_payload   = 1'b1;
        res.decoded_total = tot_inc;
      end
      hcbd_pkg::PH_DTRAIL: begin
        if (is_lf) begin
          phase_next = hcbd_pkg::PH_SIZE;
          count_next = '0;
        end
      end
      hcbd_pkg::PH_TRAILER: begin
        if (is_lf) begin
          if (cnt != '0) begin
            phase_next        = hcbd_pkg::PH_DONE;
            res_valid         = 1'b1;
            res.body_done     = 1'b1;
            res.decoded_total = tot;
          end else begin
            count_next = COUNT_BITS'(1);
          end
        end else if (!is_cr) begin
          count_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/hcbd_queue.sv */
// ----------------------------------------------------------------------------
// hcbd_queue
// Two-entry result queue that decouples the parser from output stalls.
// ----------------------------------------------------------------------------
module hcbd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hcbd_pkg::result_t push_data,
  output logic              full,
  output logic              result_valid,
  input  logic              result_stall,
  output hcbd_pkg::result_t result,
  output logic [1:0]        fill
);

  hcbd_pkg::result_t slot0;
  hcbd_pkg::result_t slot1;
  logic              pop;

  assign full         = (fill == 2'd2);
  assign result_valid = (fill != 2'd0);
  assign result       = slot0;
  assign pop          = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10: begin
          if (fill == 2'd0) begin
            slot0 <= push_data;
          end else begin
            slot1 <= push_data;
          end
          fill <= fill + 2'd1;
        end
        2'b01: begin
          slot0 <= slot1;
          fill  <= fill - 2'd1;
        end
        2'b11: begin
          if (fill == 2'd1) begin
            slot0 <= push_data;
          end else begin
            slot0 <= slot1;
            slot1 <= push_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
